// File: rtl/nss_pkg.sv
// nss_pkg: shared types and constants for the nearest segment search block
// no dependencies; imported by the channel interfaces and the top level
`default_nettype none
package nss_pkg;

  localparam int unsigned MaxWalls  = 64;
  localparam int unsigned SlotW     = $clog2(MaxWalls);
  localparam int unsigned CoordW    = 20;
  localparam int unsigned ThickW    = 16;
  localparam int unsigned TolW      = 20;
  localparam int unsigned CountW    = 7;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 20;
  localparam int unsigned PosW      = 21;
  localparam int unsigned DistW     = 21;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTolerance = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgWallCount = 1'b1;

  // action codes
  localparam logic ActWrite = 1'b0;
  localparam logic ActQuery = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [SlotW-1:0]         wall_slot;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic [ThickW-1:0]        thickness;
    logic signed [CoordW-1:0] query_x;
    logic signed [CoordW-1:0] query_y;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic [SlotW-1:0]         hit_slot;
    logic [PosW-1:0]          along_dist;
    logic signed [CoordW-1:0] projected_x;
    logic signed [CoordW-1:0] projected_y;
    logic [DistW-1:0]         distance;
  } out_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic [ThickW-1:0]        th;
  } wall_t;

endpackage
`default_nettype wire

// File: rtl/nss_if.sv
// nss_if: valid/ready channel interfaces for query input and result output
// depends on nss_pkg for the payload structs
`default_nettype none
interface nss_in_if;
  logic              valid;
  logic              ready;
  nss_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface nss_out_if;
  logic               valid;
  logic               ready;
  nss_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/nearest_segment_search.sv
// nearest_segment_search: wall table plus sequenced nearest wall search
// depends on nss_pkg and the channel interfaces in nss_if.sv
//
// A write transaction stores one wall and yields no result.
// A query transaction scans slots 0 to min(wall_count, 64)-1, one wall at a
// time, with one shared 23x23 multiplier, a radix-2 divider and a bit-serial
// square root unit; the divider is skipped when t clamps. Input is not ready
// while a query runs; one finished result may wait in the output register
// meanwhile.
`default_nettype none
module nearest_segment_search (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  nss_in_if.sink                       in_i,
  nss_out_if.source                    out_o,
  input  wire                          cfg_we_i,
  input  wire [nss_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [nss_pkg::CfgDataW-1:0]  cfg_data_i
);
  import nss_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SCAN = 5'd1;
  localparam logic [4:0] S_LOAD = 5'd2;
  localparam logic [4:0] S_L1   = 5'd3;
  localparam logic [4:0] S_L2   = 5'd4;
  localparam logic [4:0] S_D1   = 5'd5;
  localparam logic [4:0] S_D2   = 5'd6;
  localparam logic [4:0] S_DIV  = 5'd7;
  localparam logic [4:0] S_FX   = 5'd8;
  localparam logic [4:0] S_FY   = 5'd9;
  localparam logic [4:0] S_E1   = 5'd10;
  localparam logic [4:0] S_E2   = 5'd11;
  localparam logic [4:0] S_SQD  = 5'd12;
  localparam logic [4:0] S_CMP  = 5'd13;
  localparam logic [4:0] S_SQL  = 5'd14;
  localparam logic [4:0] S_POS  = 5'd15;
  localparam logic [4:0] S_DONE = 5'd16;

  logic [4:0] state_q, state_d;

  logic [TolW-1:0]   tol_q;
  logic [CountW-1:0] count_q;

  wall_t mem [MaxWalls];
  wall_t rd_q;

  logic signed [CoordW-1:0] qx_q, qx_d, qy_q, qy_d;
  logic [CountW-1:0] n_q, n_d, i_q, i_d;
  logic [4:0]  iter_q, iter_d;
  logic signed [20:0] abx_q, abx_d, aby_q, aby_d, relx_q, relx_d, rely_q, rely_d;
  logic signed [45:0] acc_q, acc_d;
  logic [41:0] lensq_q, lensq_d;
  logic [42:0] rem_q, rem_d;
  logic [16:0] t_q, t_d;
  logic signed [20:0] px_q, px_d, py_q, py_d;
  logic [43:0] sqx_q, sqx_d;
  logic [24:0] sqr_q, sqr_d;
  logic [21:0] root_q, root_d;
  logic [21:0] cand_q, cand_d;
  logic found_q, found_d;
  logic [SlotW-1:0] bslot_q, bslot_d;
  logic [PosW-1:0] bpos_q, bpos_d;
  logic signed [CoordW-1:0] bpx_q, bpx_d, bpy_q, bpy_d;
  logic [21:0] bd_q, bd_d;
  logic out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;

  logic signed [22:0] ma, mb;
  logic signed [45:0] prod, sum;
  logic signed [21:0] dx, dy;
  logic [43:0] rem2;
  logic [24:0] sq_n, sq_trial;
  logic [36:0] rnd;
  logic [20:0] rmag;
  logic [21:0] reach;
  logic wr_en;

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;
  assign wr_en = in_i.valid && in_i.ready && (in_i.data.action == ActWrite);

  assign dx = 22'(qx_q) - 22'(px_q);
  assign dy = 22'(qy_q) - 22'(py_q);

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      S_L1:    begin ma = 23'(abx_q);  mb = 23'(abx_q); end
      S_L2:    begin ma = 23'(aby_q);  mb = 23'(aby_q); end
      S_D1:    begin ma = 23'(relx_q); mb = 23'(abx_q); end
      S_D2:    begin ma = 23'(rely_q); mb = 23'(aby_q); end
      S_FX:    begin
        ma = $signed({2'b00, abx_q[20] ? 21'(-abx_q) : abx_q});
        mb = $signed({6'd0, t_q});
      end
      S_FY:    begin
        ma = $signed({2'b00, aby_q[20] ? 21'(-aby_q) : aby_q});
        mb = $signed({6'd0, t_q});
      end
      S_E1:    begin ma = 23'(dx); mb = 23'(dx); end
      S_E2:    begin ma = 23'(dy); mb = 23'(dy); end
      S_POS:   begin ma = $signed({1'b0, root_q}); mb = $signed({6'd0, t_q}); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod = ma * mb;
  assign sum  = acc_q + prod;
  assign rem2 = {rem_q, 1'b0};
  assign sq_n = {sqr_q[22:0], sqx_q[43:42]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign rnd  = prod[36:0] + 37'd32768;
  assign rmag = rnd[36:16];
  assign reach = 22'(tol_q) + 22'(rd_q.th[ThickW-1:1]);

  always_comb begin
    state_d = state_q;
    qx_d = qx_q; qy_d = qy_q; n_d = n_q; i_d = i_q; iter_d = iter_q;
    abx_d = abx_q; aby_d = aby_q; relx_d = relx_q; rely_d = rely_q;
    acc_d = acc_q; lensq_d = lensq_q; rem_d = rem_q; t_d = t_q;
    px_d = px_q; py_d = py_q; sqx_d = sqx_q; sqr_d = sqr_q; root_d = root_q;
    cand_d = cand_q; found_d = found_q; bslot_d = bslot_q; bpos_d = bpos_q;
    bpx_d = bpx_q; bpy_d = bpy_q; bd_d = bd_q;
    out_valid_d = out_valid_q; out_data_d = out_data_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    // sqrt step, used in S_SQD and S_SQL
    if (state_q == S_SQD || state_q == S_SQL) begin
      sqx_d = {sqx_q[41:0], 2'b00};
      iter_d = iter_q + 5'd1;
      if (sq_n >= sq_trial) begin
        sqr_d  = sq_n - sq_trial;
        root_d = {root_q[20:0], 1'b1};
      end else begin
        sqr_d  = sq_n;
        root_d = {root_q[20:0], 1'b0};
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid && in_i.data.action == ActQuery) begin
          qx_d = in_i.data.query_x;
          qy_d = in_i.data.query_y;
          n_d = (count_q > CountW'(MaxWalls)) ? CountW'(MaxWalls) : count_q;
          i_d = '0;
          found_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: state_d = (i_q >= n_q) ? S_DONE : S_LOAD;
      S_LOAD: begin
        abx_d  = 21'(rd_q.bx) - 21'(rd_q.ax);
        aby_d  = 21'(rd_q.by) - 21'(rd_q.ay);
        relx_d = 21'(qx_q) - 21'(rd_q.ax);
        rely_d = 21'(qy_q) - 21'(rd_q.ay);
        state_d = S_L1;
      end
      S_L1: begin
        acc_d = prod;
        state_d = S_L2;
      end
      S_L2: begin
        lensq_d = sum[41:0];
        if (sum == '0) begin
          i_d = i_q + 1'b1;
          state_d = S_SCAN;
        end else begin
          state_d = S_D1;
        end
      end
      S_D1: begin
        acc_d = prod;
        state_d = S_D2;
      end
      S_D2: begin
        if (sum <= 0) begin
          t_d = '0;
          state_d = S_FX;
        end else if (sum >= $signed({4'd0, lensq_q})) begin
          t_d = 17'h10000;
          state_d = S_FX;
        end else begin
          rem_d = sum[42:0];
          t_d = '0;
          iter_d = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (rem2 >= {2'b00, lensq_q}) begin
          rem_d = 43'(rem2 - {2'b00, lensq_q});
          t_d = {t_q[15:0], 1'b1};
        end else begin
          rem_d = rem2[42:0];
          t_d = {t_q[15:0], 1'b0};
        end
        iter_d = iter_q + 5'd1;
        if (iter_q == 5'd15) state_d = S_FX;
      end
      S_FX: begin
        px_d = abx_q[20] ? 21'(rd_q.ax) - $signed(rmag) : 21'(rd_q.ax) + $signed(rmag);
        state_d = S_FY;
      end
      S_FY: begin
        py_d = aby_q[20] ? 21'(rd_q.ay) - $signed(rmag) : 21'(rd_q.ay) + $signed(rmag);
        state_d = S_E1;
      end
      S_E1: begin
        acc_d = prod;
        state_d = S_E2;
      end
      S_E2: begin
        sqx_d = sum[43:0];
        sqr_d = '0;
        root_d = '0;
        iter_d = '0;
        state_d = S_SQD;
      end
      S_SQD: begin
        if (iter_q == 5'd21) begin
          cand_d = root_d;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (cand_q <= reach && (!found_q || cand_q < bd_q)) begin
          sqx_d = {2'b00, lensq_q};
          sqr_d = '0;
          root_d = '0;
          iter_d = '0;
          state_d = S_SQL;
        end else begin
          i_d = i_q + 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SQL: begin
        if (iter_q == 5'd21) state_d = S_POS;
      end
      S_POS: begin
        found_d = 1'b1;
        bslot_d = i_q[SlotW-1:0];
        bpos_d  = prod[36:16];
        bpx_d   = px_q[CoordW-1:0];
        bpy_d   = py_q[CoordW-1:0];
        bd_d    = cand_q;
        i_d = i_q + 1'b1;
        state_d = S_SCAN;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d.hit            = found_q;
          out_data_d.hit_slot       = found_q ? bslot_q : '0;
          out_data_d.along_dist     = found_q ? bpos_q : '0;
          out_data_d.projected_x    = found_q ? bpx_q : '0;
          out_data_d.projected_y    = found_q ? bpy_q : '0;
          out_data_d.distance       = found_q ? bd_q[DistW-1:0] : '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      tol_q       <= TolW'(200);
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgTolerance: tol_q   <= cfg_data_i[TolW-1:0];
          CfgWallCount: count_q <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q <= qx_d; qy_q <= qy_d; n_q <= n_d; i_q <= i_d; iter_q <= iter_d;
    abx_q <= abx_d; aby_q <= aby_d; relx_q <= relx_d; rely_q <= rely_d;
    acc_q <= acc_d; lensq_q <= lensq_d; rem_q <= rem_d; t_q <= t_d;
    px_q <= px_d; py_q <= py_d; sqx_q <= sqx_d; sqr_q <= sqr_d; root_q <= root_d;
    cand_q <= cand_d; bslot_q <= bslot_d; bpos_q <= bpos_d;
    bpx_q <= bpx_d; bpy_q <= bpy_d; bd_q <= bd_d;
    out_data_q <= out_data_d;
  end

  // wall table, registered read at the current scan slot
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[in_i.data.wall_slot] <= '{ax: in_i.data.start_x, ay: in_i.data.start_y,
                                    bx: in_i.data.end_x, by: in_i.data.end_y,
                                    th: in_i.data.thickness};
    end
    rd_q <= mem[i_q[SlotW-1:0]];
  end

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> {1'b0, rem_q} < {2'b00, lensq_q})
    else $error("divider remainder out of range");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.data.hit) |-> (out_o.data.hit_slot == '0 &&
      out_o.data.distance == '0 && out_o.data.along_dist == '0))
    else $error("miss result carries nonzero fields");

  a_hit_reach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && found_q) |->
      (bd_q <= 22'(tol_q) + 22'(16'hffff >> 1)))
    else $error("winning distance beyond any reach");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> (i_q < n_q && n_q <= CountW'(MaxWalls)))
    else $error("scan index past searched range");

endmodule
`default_nettype wire

// File: tb/nss_checker.sv
// nss_checker: watches the query and result channels and the register port,
// predicts every result and compares it; depends on nss_pkg and nss_if.sv
`default_nettype none
module nss_checker (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  nss_in_if                            in_ch,
  nss_out_if                           out_ch,
  input  wire                          cfg_we_i,
  input  wire [nss_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [nss_pkg::CfgDataW-1:0]  cfg_data_i,
  output int                           mismatches_o,
  output int                           pending_o
);
  import nss_pkg::*;

  logic [TolW-1:0]   tol_q;
  logic [CountW-1:0] count_q;
  wall_t             walls_q [MaxWalls];
  out_item_t         expected_hits [$];

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // d * t / 65536 rounded half away from zero
  function automatic longint frac_of(longint d, longint t);
    longint unsigned mag;
    longint unsigned r;
    mag = (d < 0) ? -d : d;
    r   = (mag * t + 32768) >> 16;
    return (d < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic out_item_t predict_query(in_item_t q);
    out_item_t       res;
    int              n;
    bit              found;
    longint unsigned best_d, d, reach, tq;
    longint          qx, qy, ax, ay, abx, aby, len_sq, dotp, t, px, py, dx, dy;
    res   = '0;
    found = 0;
    best_d = 0;
    qx = q.query_x;
    qy = q.query_y;
    n  = (count_q > MaxWalls) ? MaxWalls : count_q;
    for (int i = 0; i < n; i++) begin
      ax  = walls_q[i].ax;
      ay  = walls_q[i].ay;
      abx = longint'(walls_q[i].bx) - ax;
      aby = longint'(walls_q[i].by) - ay;
      len_sq = abx * abx + aby * aby;
      if (len_sq == 0) continue;
      dotp = (qx - ax) * abx + (qy - ay) * aby;
      if (dotp <= 0) begin
        t = 0;
      end else begin
        tq = (longint'(unsigned'(dotp)) << 16) / longint'(unsigned'(len_sq));
        t  = (tq > 65536) ? 65536 : tq;
      end
      px = ax + frac_of(abx, t);
      py = ay + frac_of(aby, t);
      dx = qx - px;
      dy = qy - py;
      d  = floor_sqrt(dx * dx + dy * dy);
      reach = tol_q + (walls_q[i].th >> 1);
      if (d <= reach && (!found || d < best_d)) begin
        found  = 1;
        best_d = d;
        res.hit            = 1'b1;
        res.hit_slot       = i[SlotW-1:0];
        res.projected_x    = px[CoordW-1:0];
        res.projected_y    = py[CoordW-1:0];
        res.distance       = d[DistW-1:0];
        res.along_dist     = PosW'((t * floor_sqrt(len_sq)) >> 16);
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    in_item_t  it;
    if (!rst_ni) begin
      tol_q   <= TolW'(200);
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgTolerance) tol_q <= cfg_data_i[TolW-1:0];
        else if (cfg_idx_i == CfgWallCount) count_q <= cfg_data_i[CountW-1:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        it = in_ch.data;
        if (it.action == ActWrite) begin
          walls_q[it.wall_slot] <= '{ax: it.start_x, ay: it.start_y, bx: it.end_x,
                                     by: it.end_y, th: it.thickness};
        end else begin
          expected_hits.push_back(predict_query(it));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_hits.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10) $display("unexpected result transaction %p", out_ch.data);
        end else begin
          want = expected_hits.pop_front();
          if (want.hit !== out_ch.data.hit || want.hit_slot !== out_ch.data.hit_slot ||
              want.along_dist !== out_ch.data.along_dist ||
              want.projected_x !== out_ch.data.projected_x ||
              want.projected_y !== out_ch.data.projected_y ||
              want.distance !== out_ch.data.distance) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("result mismatch: expected %p actual %p", want, out_ch.data);
          end
        end
      end
      pending_o = expected_hits.size();
    end
  end
endmodule
`default_nettype wire

// File: tb/nearest_segment_search_tb.sv
// nearest_segment_search_tb: stimulus, handshake pacing and verdict
// depends on nss_pkg, nss_if.sv, the block and tb/nss_checker.sv
`default_nettype none
module nearest_segment_search_tb;
  import nss_pkg::*;

  localparam int CycleLimit = 4000000;
  localparam int InW = $bits(in_item_t);

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  int                  mismatches;
  int                  pending;
  int                  cycles = 0;
  bit                  long_hold = 0;

  nss_in_if  in_ch ();
  nss_out_if out_ch ();

  nearest_segment_search u_dut (
    .clk_i(clk), .rst_ni(rst_n), .in_i(in_ch), .out_o(out_ch),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  nss_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[nearest_segment_search] ERROR");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
  end

  // result side pacing, with one long hold-off on request
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = long_hold ? 3000 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        long_hold = 0;
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_regs(int unsigned tol, int unsigned cnt);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgTolerance;
    cfg_data <= CfgDataW'(tol);
    @(posedge clk);
    cfg_idx  <= CfgWallCount;
    cfg_data <= CfgDataW'(cnt);
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [CoordW-1:0] near_coord(int span);
    return CoordW'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic in_item_t wall_item(int slot, int span);
    in_item_t it;
    it = InW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.action    = ActWrite;
    it.wall_slot = SlotW'(slot);
    if (span == 0) begin
      it.start_x = CoordW'($urandom); it.start_y = CoordW'($urandom);
      it.end_x   = CoordW'($urandom); it.end_y   = CoordW'($urandom);
    end else begin
      it.start_x = near_coord(span); it.start_y = near_coord(span);
      it.end_x   = near_coord(span); it.end_y   = near_coord(span);
    end
    it.thickness = ThickW'(($urandom_range(0, 9) == 0) ? $urandom
                                                       : $urandom_range(0, 600));
    return it;
  endfunction

  function automatic in_item_t query_item(int span);
    in_item_t it;
    it = InW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.action = ActQuery;
    if (span != 0) begin
      it.query_x = near_coord(span);
      it.query_y = near_coord(span);
    end
    return it;
  endfunction

  function automatic in_item_t random_item();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return wall_item($urandom_range(0, 63), (sel == 0) ? 0 : 2048);
    return query_item((sel == 3) ? 0 : 2600);
  endfunction

  initial begin
    in_item_t    it;
    int unsigned tols [8] = '{0, 1048575, 300, 0, 1500, 50, 0, 200};
    int unsigned cnts [8] = '{1, 64, 127, 0, 8, 3, 16, 0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole table first so that any count only scans written slots
    for (int s = 0; s < MaxWalls; s++) send_item(wall_item(s, 2048));
    // extreme wall, zero-length wall, horizontal wall
    it = wall_item(0, 2048);
    it.start_x = CoordW'(-524288); it.start_y = CoordW'(-524288);
    it.end_x = CoordW'(524287); it.end_y = CoordW'(524287);
    it.thickness = 16'hffff;
    send_item(it);
    it = wall_item(1, 2048);
    it.end_x = it.start_x; it.end_y = it.start_y;
    send_item(it);
    it = wall_item(2, 0);
    it.start_x = CoordW'(524287); it.start_y = '0;
    it.end_x = CoordW'(-524288); it.end_y = '0;
    it.thickness = '0;
    send_item(it);

    // reset settings: count zero, no wall searched
    send_item(query_item(100));
    tols[3] = $urandom_range(0, 1048575);
    tols[6] = $urandom_range(0, 5000);
    cnts[6] = $urandom_range(0, 64);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      write_regs(tols[ph], cnts[ph]);
      if (ph < 3) begin
        // directed queries: both extremes, the origin, beyond the ends of walls
        it = query_item(0);
        it.query_x = CoordW'(-524288); it.query_y = CoordW'(-524288); send_item(it);
        it.query_x = CoordW'(524287);  it.query_y = CoordW'(524287);  send_item(it);
        it.query_x = CoordW'(524287);  it.query_y = CoordW'(-524288); send_item(it);
        it.query_x = '0;               it.query_y = '0;               send_item(it);
        send_item(query_item(2600));
      end
      if (ph == 5) long_hold = 1;
      for (int k = 0; k < 7; k++) send_item(random_item());
    end

    wait_idle();
    repeat (6000) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[nearest_segment_search] OK");
    end else begin
      $display("[nearest_segment_search] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
